// ----- src/u8fold_pkg.sv -----
// Shared types, constants and the lead-byte classifier for the UTF-8 fold block.
`default_nettype none

package u8fold_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LEAD = 2'd1,
		ST_CUT      = 2'd2
	} status_t;

	// Code points that get folded
	localparam logic [15:0] FOLD_LO    = 16'hFF01;
	localparam logic [15:0] FOLD_HI    = 16'hFF5E;
	localparam logic [15:0] FOLD_DELTA = 16'hFEE0;
	localparam logic [15:0] CP_COMMA   = 16'hFF64;
	localparam logic [15:0] CP_TILDE   = 16'h301C;
	localparam logic [7:0]  ASCII_COMMA = 8'h2C;
	localparam logic [7:0]  ASCII_TILDE = 8'h7E;

	// Lead byte class masks
	localparam logic [7:0] LEAD3_MASK = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;

	// One input transfer
	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_end;
	} text_t;

	// One result transfer
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_done;
		logic [1:0] status;
	} result_t;

	// Work item handed from front to back: up to four bytes to send
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            text_end;
		status_t         status;
	} job_t;

	// Character length announced by a lead byte, 0 when it is no lead
	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		begin
			if (b[7] == 1'b0) begin
				len = 3'd1;
			end else if ((b & LEAD3_MASK) == 8'hC0) begin
				len = 3'd2;
			end else if ((b & 8'hF0) == LEAD3_MASK) begin
				len = 3'd3;
			end else if ((b & LEAD4_MASK) == 8'hF0) begin
				len = 3'd4;
			end else begin
				len = 3'd0;
			end
			return len;
		end
	endfunction

endpackage

`default_nettype wire

// ----- src/u8fold_front.sv -----
// Front end: collects characters, decodes and classifies them into jobs.
`default_nettype none

module u8fold_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire u8fold_pkg::text_t   text,
	output u8fold_pkg::job_t         job,
	output logic                     job_valid
);

	logic [1:0]      seen_q;
	logic [2:0]      len_q;
	logic [7:0]      bytes_q [3];

	logic [1:0]      seen_d;
	logic [2:0]      len_d;
	logic            store;
	logic [1:0]      store_idx;
	logic [2:0]      lead_len;
	logic [2:0]      seen_inc;
	logic [15:0]     cp;
	logic [15:0]     folded;
	logic [1:0]      last_idx;
	logic [7:0]      b;

	assign b        = text.text_byte;
	assign lead_len = u8fold_pkg::lead_length(b);
	assign seen_inc = {1'b0, seen_q} + 3'd1;
	assign cp       = {bytes_q[0][3:0], bytes_q[1][5:0], b[5:0]};
	assign folded   = cp - u8fold_pkg::FOLD_DELTA;
	assign last_idx = 2'(len_q - 3'd1);

	// Classify the byte against the pending character
	always_comb begin
		seen_d    = seen_q;
		len_d     = len_q;
		store     = 1'b0;
		store_idx = seen_q;
		job_valid = 1'b0;
		job.bytes    = '0;
		job.last_idx = 2'd0;
		job.text_end = text.text_end;
		job.status   = u8fold_pkg::ST_OK;

		if (seen_q == 2'd0) begin
			if (lead_len == 3'd0) begin
				job_valid  = 1'b1;
				job.status = u8fold_pkg::ST_BAD_LEAD;
			end else if (lead_len == 3'd1) begin
				job_valid    = 1'b1;
				job.bytes[0] = b;
			end else begin
				store     = 1'b1;
				store_idx = 2'd0;
				len_d     = lead_len;
				seen_d    = 2'd1;
			end
		end else if (seen_inc >= len_q) begin
			// Character complete: fold or pass the original bytes
			job_valid = 1'b1;
			seen_d    = 2'd0;
			len_d     = 3'd0;
			if (len_q == 3'd3 && cp >= u8fold_pkg::FOLD_LO && cp <= u8fold_pkg::FOLD_HI) begin
				job.bytes[0] = folded[7:0];
			end else if (len_q == 3'd3 && cp == u8fold_pkg::CP_COMMA) begin
				job.bytes[0] = u8fold_pkg::ASCII_COMMA;
			end else if (len_q == 3'd3 && cp == u8fold_pkg::CP_TILDE) begin
				job.bytes[0] = u8fold_pkg::ASCII_TILDE;
			end else begin
				job.bytes[0]        = bytes_q[0];
				job.bytes[1]        = bytes_q[1];
				job.bytes[2]        = bytes_q[2];
				job.bytes[last_idx] = b;
				job.last_idx        = last_idx;
			end
		end else begin
			store  = 1'b1;
			seen_d = seen_inc[1:0];
		end

		// Text ends inside a character: drop it and report
		if (text.text_end && seen_d != 2'd0) begin
			job_valid    = 1'b1;
			job.bytes    = '0;
			job.last_idx = 2'd0;
			job.status   = u8fold_pkg::ST_CUT;
			seen_d       = 2'd0;
			len_d        = 3'd0;
		end
	end

	// Advance character state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 2'd0;
			len_q  <= 3'd0;
		end else if (accept) begin
			seen_q <= seen_d;
			len_q  <= len_d;
		end
	end

	// Hold collected bytes of the pending character
	always_ff @(posedge clk) begin
		if (accept && store) begin
			bytes_q[store_idx] <= b;
		end
	end

endmodule

`default_nettype wire

// ----- src/u8fold_queue.sv -----
// Short job queue that decouples the front end from the output sequencer.
`default_nettype none

module u8fold_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire u8fold_pkg::job_t  push_job,
	input  wire logic              pop,
	output u8fold_pkg::job_t       head,
	output logic                   full,
	output logic                   empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	u8fold_pkg::job_t  mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/u8fold_back.sv -----
// Back end: sends the bytes of each queued job one transfer at a time.
`default_nettype none

module u8fold_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire u8fold_pkg::job_t    head,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output u8fold_pkg::result_t      result
);

	logic [1:0] idx_q;
	logic       is_last;
	logic       accept;

	assign is_last      = (idx_q == head.last_idx);
	assign result_valid = !empty;
	assign accept       = result_valid && !result_stall;
	assign pop          = accept && is_last;

	// Select the current byte of the head job
	always_comb begin
		result.out_byte  = head.bytes[idx_q];
		result.run_last  = is_last;
		result.text_done = is_last && head.text_end;
		result.status    = head.status;
	end

	// Step through the job, restart on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (accept) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

// ----- src/utf8_fullwidth_to_ascii_folder.sv -----
// Top level of the UTF-8 fullwidth-to-ASCII folder.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   text     | text_valid / text_stall    | text_byte, text_end
//   result   | result_valid / result_stall| out_byte, run_last, text_done, status
//
// One text byte is taken per cycle while the job queue has room; the front end
// decodes in the same cycle and pushes at most one job per byte.
// The back end sends one result byte per cycle from the queue head while
// result_stall is low; text_stall rises only when the queue is full.
// Reset clears the character state, queue pointers and byte index.
`default_nettype none

module utf8_fullwidth_to_ascii_folder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 text_valid,
	output logic                      text_stall,
	input  wire u8fold_pkg::text_t    text,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output u8fold_pkg::result_t       result
);

	u8fold_pkg::job_t  job;
	u8fold_pkg::job_t  head;
	logic              job_valid;
	logic              accept;
	logic              full;
	logic              empty;
	logic              pop;

	assign text_stall = full;
	assign accept     = text_valid && !text_stall;

	u8fold_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text      (text),
		.job       (job),
		.job_valid (job_valid)
	);

	u8fold_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && job_valid),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	u8fold_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
